/* rtl/thse_pkg.sv */
// Shared types and decode constants for the Thumb subset execute block.
`default_nettype none
package thse_pkg;

   // Decode: top five bits of the first halfword
   localparam logic [4:0] TOP5_ADDSUB = 5'b00011;
   localparam logic [4:0] TOP5_B      = 5'h1C;
   localparam logic [4:0] TOP5_BL     = 5'h1E;

   // Decode: top three bits of the first halfword
   localparam logic [2:0] TOP3_SHIFT  = 3'b000;
   localparam logic [2:0] TOP3_IMM8   = 3'b001;

   // Shift opcodes, bits 12:11
   localparam logic [1:0] SHOP_LSL    = 2'd0;
   localparam logic [1:0] SHOP_LSR    = 2'd1;
   localparam logic [1:0] SHOP_ASR    = 2'd2;
   localparam logic [1:0] SHOP_NONE   = 2'd3;

   // 8-bit immediate opcodes, bits 12:11
   localparam logic [1:0] IMOP_MOV    = 2'd0;
   localparam logic [1:0] IMOP_CMP    = 2'd1;
   localparam logic [1:0] IMOP_ADD    = 2'd2;
   localparam logic [1:0] IMOP_SUB    = 2'd3;

   // Register numbers and masks
   localparam logic [3:0]  LINK_REG_INDEX = 4'd14;
   localparam logic [31:0] TARGET_MASK    = 32'hFFFF_FFFE;
   localparam logic [31:0] LINK_THUMB_BIT = 32'h0000_0001;

   // Flag bit positions
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   typedef struct packed {
      logic [15:0] first_halfword;
      logic [15:0] second_halfword;
      logic [31:0] pc_value;
   } req_type;

   typedef struct packed {
      logic        branch_taken;
      logic [31:0] branch_target;
      logic        reg_written;
      logic [3:0]  dest_index;
      logic [31:0] dest_value;
      logic [3:0]  flags_nzcv;
      logic        invalid_op;
   } rsp_type;

   // Low register file write port
   typedef struct packed {
      logic        en;
      logic [2:0]  addr;
      logic [31:0] data;
   } wr_type;

endpackage
`default_nettype wire

/* rtl/thse_regfile.sv */
// Eight low registers with two registered read ports and write-through forwarding.
`default_nettype none
module thse_regfile (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            rd_en,
   input  wire logic [2:0]      rd_addr_a,
   input  wire logic [2:0]      rd_addr_b,
   input  wire thse_pkg::wr_type wr,
   output logic [31:0]          rd_data_a,
   output logic [31:0]          rd_data_b
);
   import thse_pkg::*;

   logic [31:0] mem [8];
   logic [7:0]  valid_ff;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic [31:0] rd_a_in;
   logic [31:0] rd_b_in;

   // Read with bypass of a same-cycle write; unwritten entries read as zero
   always_comb begin
      rd_a_in = valid_ff[rd_addr_a] ? mem[rd_addr_a] : 32'd0;
      rd_b_in = valid_ff[rd_addr_b] ? mem[rd_addr_b] : 32'd0;
      if (wr.en && wr.addr == rd_addr_a) begin
         rd_a_in = wr.data;
      end
      if (wr.en && wr.addr == rd_addr_b) begin
         rd_b_in = wr.data;
      end
   end

   // Storage and write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Written markers, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= rd_a_in;
         rd_b_ff <= rd_b_in;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

/* rtl/thse_alu.sv */
// Decode and execute of one instruction: shifter, adder and branch target.
`default_nettype none
module thse_alu (
   input  wire thse_pkg::req_type req,
   input  wire logic [31:0]       op_a,
   input  wire logic [31:0]       op_b,
   input  wire logic [3:0]        flags,
   output thse_pkg::rsp_type      rsp,
   output thse_pkg::wr_type       wr
);
   import thse_pkg::*;

   logic [15:0] h1;
   logic [15:0] h2;
   logic [4:0]  top5;
   logic        is_shift;
   logic        is_addsub;
   logic        is_imm8;
   logic        is_b;
   logic        is_bl;
   logic [1:0]  sh_op;
   logic [4:0]  sh_n;
   logic [5:0]  sh_amt;
   logic [32:0] lsl_tmp;
   logic [64:0] rsh_tmp;
   logic        sh_fill;
   logic [31:0] sh_res;
   logic        sh_c;
   logic [31:0] add_x;
   logic [31:0] add_y;
   logic        add_cin;
   logic [32:0] add_sum;
   logic [31:0] add_res;
   logic        add_v;
   logic [31:0] b_off;
   logic [31:0] bl_off;
   logic        bl_s;
   logic [31:0] br_sum;
   logic [1:0]  im_op;

   assign h1   = req.first_halfword;
   assign h2   = req.second_halfword;
   assign top5 = h1[15:11];

   // Instruction class decode
   assign is_shift  = (h1[15:13] == TOP3_SHIFT) && (h1[12:11] != SHOP_NONE);
   assign is_addsub = (top5 == TOP5_ADDSUB);
   assign is_imm8   = (h1[15:13] == TOP3_IMM8);
   assign is_b      = (top5 == TOP5_B);
   assign is_bl     = (top5 == TOP5_BL) && h2[15] && h2[14] && h2[12];

   // Shifter: amount 0 is a copy for LSL and 32 for LSR/ASR
   assign sh_op   = h1[12:11];
   assign sh_n    = h1[10:6];
   assign sh_amt  = (sh_n == 5'd0) ? 6'd32 : {1'b0, sh_n};
   assign sh_fill = (sh_op == SHOP_ASR) && op_a[31];
   assign lsl_tmp = {1'b0, op_a} << sh_n;
   assign rsh_tmp = {{32{sh_fill}}, op_a, 1'b0} >> sh_amt;

   always_comb begin
      if (sh_op == SHOP_LSL) begin
         if (sh_n == 5'd0) begin
            sh_res = op_a;
            sh_c   = flags[FLAG_C];
         end else begin
            sh_res = lsl_tmp[31:0];
            sh_c   = lsl_tmp[32];
         end
      end else begin
         sh_res = rsh_tmp[32:1];
         sh_c   = rsh_tmp[0];
      end
   end

   // Adder operand select: subtract is add of the inverse plus one
   assign im_op = h1[12:11];

   always_comb begin
      if (is_addsub) begin
         add_x   = op_a;
         add_y   = h1[10] ? {29'd0, h1[8:6]} : op_b;
         add_cin = h1[9];
      end else begin
         add_x   = op_a;
         add_y   = {24'd0, h1[7:0]};
         add_cin = (im_op != IMOP_ADD);
      end
      if (add_cin) begin
         add_y = ~add_y;
      end
   end

   assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
   assign add_res = add_sum[31:0];
   assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_res[31]);

   // Branch offsets
   assign b_off  = {{20{h1[10]}}, h1[10:0], 1'b0};
   assign bl_s   = h1[10];
   assign bl_off = {{7{bl_s}}, bl_s, ~(h2[13] ^ bl_s), ~(h2[11] ^ bl_s),
                    h1[9:0], h2[10:0], 1'b0};
   assign br_sum = req.pc_value + (is_bl ? bl_off : b_off);

   // Result assembly
   always_comb begin
      rsp            = '0;
      rsp.flags_nzcv = flags;
      wr             = '0;
      if (is_shift) begin
         rsp.reg_written = 1'b1;
         rsp.dest_index  = {1'b0, h1[2:0]};
         rsp.dest_value  = sh_res;
         rsp.flags_nzcv  = {sh_res[31], sh_res == 32'd0, sh_c, flags[FLAG_V]};
      end else if (is_addsub) begin
         rsp.reg_written = 1'b1;
         rsp.dest_index  = {1'b0, h1[2:0]};
         rsp.dest_value  = add_res;
         rsp.flags_nzcv  = {add_res[31], add_res == 32'd0, add_sum[32], add_v};
      end else if (is_imm8) begin
         if (im_op == IMOP_MOV) begin
            // zero-extended immediate is never negative
            rsp.flags_nzcv = {1'b0, h1[7:0] == 8'd0, flags[FLAG_C], flags[FLAG_V]};
            rsp.dest_value = {24'd0, h1[7:0]};
         end else begin
            rsp.flags_nzcv = {add_res[31], add_res == 32'd0, add_sum[32], add_v};
            rsp.dest_value = add_res;
         end
         // compare only updates the flags
         if (im_op == IMOP_CMP) begin
            rsp.dest_value = 32'd0;
         end else begin
            rsp.reg_written = 1'b1;
            rsp.dest_index  = {1'b0, h1[10:8]};
         end
      end else if (is_b) begin
         rsp.branch_taken  = 1'b1;
         rsp.branch_target = br_sum & TARGET_MASK;
      end else if (is_bl) begin
         rsp.branch_taken  = 1'b1;
         rsp.branch_target = br_sum & TARGET_MASK;
         rsp.reg_written   = 1'b1;
         rsp.dest_index    = LINK_REG_INDEX;
         rsp.dest_value    = req.pc_value | LINK_THUMB_BIT;
      end else begin
         rsp.invalid_op = 1'b1;
      end
      // link register writes never reach the low register file
      wr.en   = rsp.reg_written && !rsp.dest_index[3];
      wr.addr = rsp.dest_index[2:0];
      wr.data = rsp.dest_value;
   end

endmodule
`default_nettype wire

/* rtl/thse_top_unused_placeholder.sv */
// Operand address select for the low register file read ports.
`default_nettype none
module thse_opsel (
   input  wire logic [15:0] first_halfword,
   output logic [2:0]       addr_a,
   output logic [2:0]       addr_b
);
   import thse_pkg::*;

   // Port A: 8-bit immediate forms read Rd/Rn from bits 10:8, the rest from bits 5:3
   assign addr_a = (first_halfword[15:13] == TOP3_IMM8) ? first_halfword[10:8]
                                                        : first_halfword[5:3];
   assign addr_b = first_halfword[8:6];

endmodule
`default_nettype wire

/* rtl/thse_opsel.sv */
// Handshake checks on the two channels of the Thumb subset execute block.
`default_nettype none
module thse_opsel_chk (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall
);
`ifndef SYNTHESIS
   // Port-level checks on the two channels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall |=> ##1 rsp_valid)
      else $error("accepted item did not reach the result port");
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");
`endif
endmodule
`default_nettype wire

/* rtl/thumb_subset_execute.sv */
// Top level of the Thumb subset execute block.
`default_nettype none
// Executes one Thumb instruction per item from a small subset (shifts by immediate,
// add/subtract, 8-bit immediate MOV/CMP/ADD/SUB, B and BL) against eight low
// registers and the NZCV flags. Throughput is one item per cycle while the result side
// does not stall. The low register file is read through its two registered ports as an
// item is accepted, so the item and its operands sit together in the input stage; the
// shifter, adder and branch adder then load the result register and write back the
// register file and flags at the same edge. A result therefore passes from the input
// stage into the result register before it is presented; register results of the preceding
// item are bypassed into the read ports, so dependent instructions run back to back. A stall
// on the result side holds both stages; the input side stalls only when the input stage cannot move on.
module thumb_subset_execute (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire thse_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output thse_pkg::rsp_type      rsp_payload
);
   import thse_pkg::*;

   logic        in_valid_ff;
   req_type     in_ff;
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic [3:0]  flags_ff;
   logic        advance;
   logic        accept;
   logic [2:0]  addr_a;
   logic [2:0]  addr_b;
   logic [31:0] op_a;
   logic [31:0] op_b;
   rsp_type     rsp_in;
   wr_type      wr;

   // Handshake
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   thse_opsel u_opsel (
      .first_halfword (req_payload.first_halfword),
      .addr_a         (addr_a),
      .addr_b         (addr_b)
   );

   thse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .wr        (advance ? wr : '0),
      .rd_data_a (op_a),
      .rd_data_b (op_b)
   );

   thse_alu u_alu (
      .req   (in_ff),
      .op_a  (op_a),
      .op_b  (op_b),
      .flags (flags_ff),
      .rsp   (rsp_in),
      .wr    (wr)
   );

   thse_opsel_chk u_chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   // Operand stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
   end

   // Execute stage: result register and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            flags_ff     <= rsp_in.flags_nzcv;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_flags_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(advance) |-> rsp_payload.flags_nzcv == flags_ff)
      else $error("reported flags differ from flag register");
   a_invalid_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.invalid_op |->
         !rsp_payload.reg_written && !rsp_payload.branch_taken)
      else $error("invalid item had side effects");
   a_link_only_bl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.reg_written && rsp_payload.dest_index[3] |->
         rsp_payload.branch_taken && rsp_payload.dest_index == LINK_REG_INDEX)
      else $error("link register written outside branch with link");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("operand stage lost an item");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the Thumb subset execute block.
`default_nettype none
module tb_top;
   import thse_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;

   // Add/subtract opcode, bits 10:9: bit 10 selects the 3-bit immediate, bit 9 subtracts
   localparam logic [1:0] ADDSUB_REG_ADD = 2'b00;
   localparam logic [1:0] ADDSUB_REG_SUB = 2'b01;
   localparam logic [1:0] ADDSUB_IMM_ADD = 2'b10;
   localparam logic [1:0] ADDSUB_IMM_SUB = 2'b11;

   // Bits 15, 14 and 12 of a BL second halfword must all be set
   localparam logic [15:0] BL_SUFFIX_MASK = 16'hD000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Architectural state mirrored by the predictor
   logic [31:0] model_low_regs [8];
   logic [31:0] model_link_reg;
   logic [3:0]  model_nzcv;

   rsp_type expected_results [$];
   rsp_type oldest_result;
   int      error_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   thumb_subset_execute DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result-side backpressure
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
   end

   // Adds with carry in, returns the sum and the NZCV flags it produces
   function automatic logic [31:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                  input logic cin, output logic [3:0] nzcv);
      logic [32:0] wide;
      logic [31:0] sum;
      wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      sum = wide[31:0];
      nzcv[FLAG_N] = sum[31];
      nzcv[FLAG_Z] = (sum == 32'd0);
      nzcv[FLAG_C] = wide[32];
      nzcv[FLAG_V] = (a[31] == b[31]) && (sum[31] != a[31]);
      return sum;
   endfunction

   // Executes one instruction against the mirrored state, returns the expected result
   function automatic rsp_type execute_instruction(input req_type item);
      rsp_type     res;
      logic [15:0] h1;
      logic [15:0] h2;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] r;
      logic [31:0] off;
      logic [3:0]  fl;
      logic [1:0]  op;
      logic        c;
      logic        s;
      int          amt;
      h1 = item.first_halfword;
      h2 = item.second_halfword;
      res = '0;
      fl = model_nzcv;
      if (h1[15:13] == TOP3_SHIFT && h1[12:11] != SHOP_NONE) begin
         // Shift by immediate; C is the last bit shifted out
         op = h1[12:11];
         amt = int'(h1[10:6]);
         x = model_low_regs[h1[5:3]];
         if (op == SHOP_LSL) begin
            if (amt == 0) begin
               r = x;
               c = model_nzcv[FLAG_C];
            end else begin
               r = x << amt;
               c = x[32 - amt];
            end
         end else begin
            if (amt == 0) amt = 32;
            c = x[amt - 1];
            if (amt == 32) begin
               r = (op == SHOP_ASR && x[31]) ? 32'hFFFF_FFFF : 32'd0;
            end else if (op == SHOP_ASR) begin
               r = $signed(x) >>> amt;
            end else begin
               r = x >> amt;
            end
         end
         fl = {r[31], r == 32'd0, c, model_nzcv[FLAG_V]};
         res.reg_written = 1'b1;
         res.dest_index = {1'b0, h1[2:0]};
         res.dest_value = r;
      end else if (h1[15:11] == TOP5_ADDSUB) begin
         // Add/subtract with register or 3-bit immediate
         op = h1[10:9];
         x = model_low_regs[h1[5:3]];
         y = op[1] ? {29'd0, h1[8:6]} : model_low_regs[h1[8:6]];
         r = op[0] ? add_with_carry(x, ~y, 1'b1, fl) : add_with_carry(x, y, 1'b0, fl);
         res.reg_written = 1'b1;
         res.dest_index = {1'b0, h1[2:0]};
         res.dest_value = r;
      end else if (h1[15:13] == TOP3_IMM8) begin
         // MOV/CMP/ADD/SUB with 8-bit immediate
         op = h1[12:11];
         x = model_low_regs[h1[10:8]];
         y = {24'd0, h1[7:0]};
         if (op == IMOP_MOV) begin
            r = y;
            fl = {r[31], r == 32'd0, model_nzcv[FLAG_C], model_nzcv[FLAG_V]};
         end else if (op == IMOP_ADD) begin
            r = add_with_carry(x, y, 1'b0, fl);
         end else begin
            r = add_with_carry(x, ~y, 1'b1, fl);
         end
         if (op != IMOP_CMP) begin
            res.reg_written = 1'b1;
            res.dest_index = {1'b0, h1[10:8]};
            res.dest_value = r;
         end
      end else if (h1[15:11] == TOP5_B) begin
         off = {{20{h1[10]}}, h1[10:0], 1'b0};
         res.branch_taken = 1'b1;
         res.branch_target = (item.pc_value + off) & TARGET_MASK;
      end else if (h1[15:11] == TOP5_BL && (h2 & BL_SUFFIX_MASK) == BL_SUFFIX_MASK) begin
         // Branch with link; I1/I2 are J1/J2 xnor S
         s = h1[10];
         off = {{7{s}}, s, ~(h2[13] ^ s), ~(h2[11] ^ s), h1[9:0], h2[10:0], 1'b0};
         model_link_reg = item.pc_value | LINK_THUMB_BIT;
         res.branch_taken = 1'b1;
         res.branch_target = (item.pc_value + off) & TARGET_MASK;
         res.reg_written = 1'b1;
         res.dest_index = LINK_REG_INDEX;
         res.dest_value = model_link_reg;
      end else begin
         res.invalid_op = 1'b1;
      end
      if (res.reg_written && res.dest_index < 4'd8) model_low_regs[res.dest_index[2:0]] =
         res.dest_value;
      model_nzcv = fl;
      res.flags_nzcv = fl;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Predict on acceptance, compare on each result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) expected_results.push_back(execute_instruction(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no pending item: 0x%0h", rsp_payload);
               error_count++;
            end else begin
               oldest_result = expected_results.pop_front();
               check_field("branch_taken", 32'(oldest_result.branch_taken),
                           32'(rsp_payload.branch_taken));
               check_field("branch_target", oldest_result.branch_target,
                           rsp_payload.branch_target);
               check_field("reg_written", 32'(oldest_result.reg_written),
                           32'(rsp_payload.reg_written));
               check_field("dest_index", 32'(oldest_result.dest_index),
                           32'(rsp_payload.dest_index));
               check_field("dest_value", oldest_result.dest_value, rsp_payload.dest_value);
               check_field("flags_nzcv", 32'(oldest_result.flags_nzcv),
                           32'(rsp_payload.flags_nzcv));
               check_field("invalid_op", 32'(oldest_result.invalid_op),
                           32'(rsp_payload.invalid_op));
            end
         end
      end
   end

   // Instruction encoders
   function automatic logic [15:0] enc_shift(input logic [1:0] op, input logic [4:0] amt,
                                             input logic [2:0] rm, input logic [2:0] rd);
      return {TOP3_SHIFT, op, amt, rm, rd};
   endfunction

   function automatic logic [15:0] enc_addsub(input logic [1:0] op, input logic [2:0] f,
                                              input logic [2:0] rn, input logic [2:0] rd);
      return {TOP5_ADDSUB, op, f, rn, rd};
   endfunction

   function automatic logic [15:0] enc_imm8(input logic [1:0] op, input logic [2:0] rd,
                                            input logic [7:0] imm);
      return {TOP3_IMM8, op, rd, imm};
   endfunction

   // Sends one item, with random idle cycles ahead of it, and waits for acceptance
   task automatic send_item(input logic [15:0] h1, input logic [15:0] h2, input logic [31:0] pc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_payload <= '0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{first_halfword: h1, second_halfword: h2, pc_value: pc};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds off the sender until every pending item has produced its result
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_immediate8();
      send_item(enc_imm8(IMOP_MOV, 3'd0, 8'd0), 16'hFFFF, 32'd0);      // zero result
      send_item(enc_imm8(IMOP_MOV, 3'd1, 8'hFF), 16'h0000, 32'd0);
      send_item(enc_imm8(IMOP_MOV, 3'd7, 8'h80), 16'h0000, 32'd0);
      send_item(enc_imm8(IMOP_CMP, 3'd1, 8'hFF), 16'h0000, 32'd0);     // equal, no write
      send_item(enc_imm8(IMOP_ADD, 3'd1, 8'hFF), 16'h0000, 32'd0);
      send_item(enc_imm8(IMOP_SUB, 3'd0, 8'd1), 16'h0000, 32'd0);      // borrow to all ones
      send_item(enc_imm8(IMOP_CMP, 3'd0, 8'd0), 16'h0000, 32'd0);
   endtask

   task automatic test_shift_immediate();
      send_item(enc_shift(SHOP_LSL, 5'd24, 3'd7, 3'd2), 16'h0000, 32'd0);  // 0x80000000
      send_item(enc_shift(SHOP_LSL, 5'd31, 3'd1, 3'd3), 16'h0000, 32'd0);
      send_item(enc_shift(SHOP_LSL, 5'd0, 3'd2, 3'd4), 16'h0000, 32'd0);   // copy, C kept
      send_item(enc_shift(SHOP_LSR, 5'd0, 3'd2, 3'd5), 16'h0000, 32'd0);   // by 32
      send_item(enc_shift(SHOP_ASR, 5'd0, 3'd2, 3'd6), 16'h0000, 32'd0);   // by 32, negative
      send_item(enc_shift(SHOP_ASR, 5'd4, 3'd2, 3'd5), 16'h0000, 32'd0);
      send_item(enc_shift(SHOP_LSR, 5'd1, 3'd0, 3'd6), 16'h0000, 32'd0);   // 0x7FFFFFFF
   endtask

   task automatic test_add_subtract();
      send_item(enc_addsub(ADDSUB_IMM_ADD, 3'd1, 3'd6, 3'd4), 16'h0000, 32'd0); // overflow
      send_item(enc_addsub(ADDSUB_REG_SUB, 3'd6, 3'd2, 3'd5), 16'h0000, 32'd0); // overflow
      send_item(enc_addsub(ADDSUB_REG_ADD, 3'd0, 3'd0, 3'd3), 16'h0000, 32'd0); // carry out
      send_item(enc_addsub(ADDSUB_IMM_SUB, 3'd7, 3'd3, 3'd3), 16'h0000, 32'd0);
      send_item(enc_addsub(ADDSUB_IMM_ADD, 3'd0, 3'd2, 3'd7), 16'h0000, 32'd0);
   endtask

   task automatic test_branches();
      send_item({TOP5_B, 11'h3FF}, 16'h0000, 32'hFFFF_FFFF);   // largest forward, wraps
      send_item({TOP5_B, 11'h400}, 16'hFFFF, 32'h0000_0000);   // largest backward
      send_item({TOP5_BL, 1'b0, 10'h3FF}, {2'b11, 1'b1, 1'b1, 1'b1, 11'h7FF}, 32'h1234_5678);
      send_item({TOP5_BL, 1'b1, 10'h000}, {2'b11, 1'b0, 1'b1, 1'b0, 11'h000}, 32'h0000_0004);
      // BL with bit 12 of the suffix clear is not a BL
      send_item({TOP5_BL, 1'b0, 10'h155}, 16'hC7FF, 32'h8000_0000);
   endtask

   task automatic test_invalid_encodings();
      send_item(16'h4000, 16'h0000, 32'd0);
      send_item(16'h8000, 16'hFFFF, 32'd0);
      send_item({5'h1D, 11'h7FF}, 16'hF800, 32'hFFFF_FFFF);
   endtask

   // Mostly well-formed instructions with random fields, plus raw noise
   task automatic test_random_traffic(input int count);
      logic [15:0] h1;
      logic [15:0] h2;
      logic [31:0] pc;
      int          kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 19);
         h2 = 16'($urandom);
         pc = ($urandom_range(0, 15) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
         if (kind <= 5) begin
            h1 = enc_shift(2'($urandom_range(0, 2)), 5'($urandom), 3'($urandom),
                           3'($urandom));
         end else if (kind <= 9) begin
            h1 = enc_addsub(2'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
         end else if (kind <= 14) begin
            h1 = enc_imm8(2'($urandom), 3'($urandom), 8'($urandom));
         end else if (kind <= 16) begin
            h1 = {TOP5_B, 11'($urandom)};
         end else if (kind <= 18) begin
            h1 = {TOP5_BL, 11'($urandom)};
            if ($urandom_range(0, 7) != 0) h2 = h2 | BL_SUFFIX_MASK;
         end else begin
            h1 = 16'($urandom);
         end
         send_item(h1, h2, pc);
      end
   endtask

   initial begin
      foreach (model_low_regs[i]) model_low_regs[i] = '0;
      model_link_reg = '0;
      model_nzcv = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 49;
      test_immediate8();
      test_shift_immediate();
      test_add_subtract();
      test_branches();
      test_invalid_encodings();
      test_random_traffic(400);
      wait_all_results();

      send_idle_pct = 49;
      recv_idle_pct = 33;
      test_random_traffic(400);
      wait_all_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(420);
      wait_all_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
